### design/seed_chain_coherence_filter_unit_macros.svh
// Assertion macros for the seed chain coherence filter RTL.
`ifndef SEED_CHAIN_COHERENCE_FILTER_UNIT_MACROS_SVH
`define SEED_CHAIN_COHERENCE_FILTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define SCCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sccf assertion failed");

`define SCCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sccf assertion failed");

`else

`define SCCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define SCCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### design/sccf_pkg.sv
// Types and constants of the seed chain coherence filter.
package sccf_pkg;

    localparam int unsigned LIST_CAPACITY = 256;
    localparam int unsigned LIST_CAP_W    = 11;

    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic {
        CFG_RD_LEN   = 1'b0,
        CFG_MAX_KEPT = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_SEED,
        KIND_CLOSE,
        KIND_EMPTY
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        first_list;
        logic        span_bad;
        logic [15:0] rd_lo;
        logic [16:0] next_read;
        logic [31:0] gn_lo;
        logic [32:0] next_genome;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic       keep;
        logic       coherent;
        logic [7:0] seed_count;
        logic [7:0] kept_position;
    } t_result;

endpackage

### design/seed_chain_coherence_filter_unit.sv
// Seed chain coherence filter: top level.
//
// Input channel (i_valid / o_ready) carries one seed word per handshake:
// read and genome span plus the last_in_location, empty_location and
// first_of_list marks. The output channel (o_valid / i_ready) carries one
// word per closed or empty location: keep, coherent, seed_count and
// kept_position. The config channel (i_cfg_valid / o_cfg_ready) writes
// the read length (index 0) or max_kept (index 1); it is always ready.
//
// A word moves through an input register, a QUEUE_DEPTH-entry FIFO and the
// checking stage, which writes the output register. One word is accepted
// per cycle, sustained, while the receiver keeps taking results; the back
// end checks each word and updates its state as it pops it, and that sets
// the rate.
// When the receiver stalls, plain seeds keep draining; a closing word waits
// at the queue head until the output register frees, and the input stalls
// once the queue and input register are full.
// Reset (synchronous, active low) empties the pipeline, opens a fresh
// location, clears the kept count and loads a read length and max_kept of 100.
module seed_chain_coherence_filter_unit
    import sccf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [15:0]           i_rd_lo,
    input  logic [15:0]           i_rd_hi,
    input  logic [31:0]           i_gn_lo,
    input  logic [31:0]           i_gn_hi,
    input  logic                  i_last_in_location,
    input  logic                  i_empty_location,
    input  logic                  i_first_of_list,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_keep,
    output logic                  o_coherent,
    output logic [7:0]            o_seed_count,
    output logic [7:0]            o_kept_position,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "seed_chain_coherence_filter_unit_macros.svh"

    t_q_status q_status;
    logic      push;
    t_item     front_item;
    logic      pop;
    t_item     head_item;
    t_result   result;

    assign o_cfg_ready = 1'b1;

    sccf_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_rd_lo           (i_rd_lo),
        .i_rd_hi           (i_rd_hi),
        .i_gn_lo           (i_gn_lo),
        .i_gn_hi           (i_gn_hi),
        .i_last_in_location(i_last_in_location),
        .i_empty_location  (i_empty_location),
        .i_first_of_list   (i_first_of_list),
        .i_q_status        (q_status),
        .o_push            (push),
        .o_item            (front_item)
    );

    sccf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_status(q_status)
    );

    sccf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_avail    (!q_status.empty),
        .i_item     (head_item),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (result)
    );

    assign o_keep          = result.keep;
    assign o_coherent      = result.coherent;
    assign o_seed_count    = result.seed_count;
    assign o_kept_position = result.kept_position;

    `SCCF_ASSERT_IMP(a_keep_needs_coherent, i_clk, i_rst_n, o_valid && o_keep, o_coherent)
    `SCCF_ASSERT_IMP(a_drop_has_no_pos, i_clk, i_rst_n, o_valid && !o_keep, o_kept_position == 8'd0)
    `SCCF_ASSERT_IMP(a_no_seeds_incoherent, i_clk, i_rst_n, o_valid && (o_seed_count == 8'd0), !o_coherent)
    `SCCF_ASSERT_NXT(a_full_queue_stalls, i_clk, i_rst_n, !o_ready && !pop, !o_ready)

endmodule

### design/sccf_front.sv
// Front end: accepts seed words, classifies them and hands them to the queue.
module sccf_front
    import sccf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_rd_lo,
    input  logic [15:0] i_rd_hi,
    input  logic [31:0] i_gn_lo,
    input  logic [31:0] i_gn_hi,
    input  logic        i_last_in_location,
    input  logic        i_empty_location,
    input  logic        i_first_of_list,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_item       o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign o_push  = r_valid && !i_q_status.full;
    assign o_ready = !r_valid || !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end

        n_item             = r_item;
        n_item.first_list  = i_first_of_list;
        n_item.span_bad    = (i_rd_lo >= i_rd_hi);
        n_item.rd_lo       = i_rd_lo;
        n_item.next_read   = {1'b0, i_rd_hi} + 17'd1;
        n_item.gn_lo       = i_gn_lo;
        n_item.next_genome = {1'b0, i_gn_hi} + 33'd1;
        if (i_empty_location) begin
            n_item.kind = KIND_EMPTY;
        end else if (i_last_in_location) begin
            n_item.kind = KIND_CLOSE;
        end else begin
            n_item.kind = KIND_SEED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

### design/sccf_queue.sv
// Short FIFO between the front end and the checking back end.
module sccf_queue
    import sccf_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item              r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

### design/sccf_back.sv
// Back end: order and gap checks, location state, kept count and result register.
module sccf_back
    import sccf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_avail,
    input  t_item                 i_item,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_result               o_result
);

    logic [15:0] r_rd_len;
    logic [7:0]  r_max_kept;
    logic [16:0] r_next_read_pos;
    logic [16:0] n_next_read_pos;
    logic [32:0] r_next_genome_pos;
    logic [32:0] n_next_genome_pos;
    logic        r_first_seed;
    logic        n_first_seed;
    logic        r_location_bad;
    logic        n_location_bad;
    logic [7:0]  r_seed_counter;
    logic [7:0]  n_seed_counter;
    logic [7:0]  r_kept_counter;
    logic [7:0]  n_kept_counter;
    logic        r_out_valid;
    logic        n_out_valid;
    t_result     r_out;
    t_result     n_out;

    logic        emits;
    logic [7:0]  kc;
    logic [32:0] gap;
    logic [32:0] limit;
    logic        bad;
    logic        keep;

    assign emits    = (i_item.kind != KIND_SEED);
    assign o_pop    = i_avail && (!emits || !r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign kc    = i_item.first_list ? 8'd0 : r_kept_counter;
    assign gap   = {1'b0, i_item.gn_lo} - r_next_genome_pos;
    assign limit = {16'd0, r_rd_len, 1'b0};

    always_comb begin
        bad = r_location_bad || i_item.span_bad;
        if (!r_first_seed) begin
            if (r_next_read_pos > {1'b0, i_item.rd_lo}) begin
                bad = 1'b1;
            end
            if (({1'b0, i_item.gn_lo} < r_next_genome_pos) || (gap > limit)) begin
                bad = 1'b1;
            end
        end
        keep = !bad && (kc < r_max_kept)
            && ({{(LIST_CAP_W - 8){1'b0}}, kc} < LIST_CAP_W'(LIST_CAPACITY));
    end

    always_comb begin
        n_next_read_pos   = r_next_read_pos;
        n_next_genome_pos = r_next_genome_pos;
        n_first_seed      = r_first_seed;
        n_location_bad    = r_location_bad;
        n_seed_counter    = r_seed_counter;
        n_kept_counter    = r_kept_counter;
        n_out             = r_out;
        n_out_valid       = r_out_valid;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        if (o_pop) begin
            n_kept_counter = kc;
            case (i_item.kind)
                KIND_EMPTY: begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                end
                KIND_CLOSE: begin
                    n_out.keep          = keep;
                    n_out.coherent      = !bad;
                    n_out.seed_count    = (r_seed_counter == 8'hFF) ? 8'hFF
                                                                    : r_seed_counter + 8'd1;
                    n_out.kept_position = keep ? kc : 8'd0;
                    n_out_valid         = 1'b1;
                    if (keep) begin
                        n_kept_counter = kc + 8'd1;
                    end
                end
                default: begin
                    n_first_seed      = 1'b0;
                    n_location_bad    = bad;
                    n_next_read_pos   = i_item.next_read;
                    n_next_genome_pos = i_item.next_genome;
                    if (r_seed_counter != 8'hFF) begin
                        n_seed_counter = r_seed_counter + 8'd1;
                    end
                end
            endcase
            if (emits) begin
                n_first_seed      = 1'b1;
                n_location_bad    = 1'b0;
                n_seed_counter    = 8'd0;
                n_next_read_pos   = '0;
                n_next_genome_pos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_len          <= 16'd100;
            r_max_kept        <= 8'd100;
            r_next_read_pos   <= '0;
            r_next_genome_pos <= '0;
            r_first_seed      <= 1'b1;
            r_location_bad    <= 1'b0;
            r_seed_counter    <= '0;
            r_kept_counter    <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RD_LEN:   r_rd_len   <= i_cfg_data;
                    CFG_MAX_KEPT: r_max_kept <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            r_next_read_pos   <= n_next_read_pos;
            r_next_genome_pos <= n_next_genome_pos;
            r_first_seed      <= n_first_seed;
            r_location_bad    <= n_location_bad;
            r_seed_counter    <= n_seed_counter;
            r_kept_counter    <= n_kept_counter;
            r_out_valid       <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

### bench/seed_chain_coherence_filter_unit_tb.sv
// Self-checking bench for the seed chain coherence filter: directed table, then random seed chains.
module seed_chain_coherence_filter_unit_tb;
    import sccf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FLUSH_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [15:0] rd_lo;
        logic [15:0] rd_hi;
        logic [31:0] gn_lo;
        logic [31:0] gn_hi;
        logic        last_in_location;
        logic        empty_location;
        logic        first_of_list;
    } t_seed_word;

    typedef struct packed {
        t_seed_word word;
        logic       typed;
        t_result    res;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [15:0]           i_rd_lo = '0;
    logic [15:0]           i_rd_hi = '0;
    logic [31:0]           i_gn_lo = '0;
    logic [31:0]           i_gn_hi = '0;
    logic                  i_last_in_location = 1'b0;
    logic                  i_empty_location = 1'b0;
    logic                  i_first_of_list = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_keep;
    logic                  o_coherent;
    logic [7:0]            o_seed_count;
    logic [7:0]            o_kept_position;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_index            i_cfg_index = CFG_RD_LEN;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // chain checker copy
    logic [15:0] cfg_read_len;
    logic [7:0]  cfg_max_kept;
    logic [16:0] chk_next_read;
    logic [32:0] chk_next_genome;
    logic        chk_first_seed;
    logic        chk_bad;
    logic [7:0]  chk_seed_cnt;
    logic [7:0]  chk_kept_cnt;

    t_result     expected_results[$];
    t_stim_row   stim_table[$];
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          ready_hold = 0;
    int          idle_cycles = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          quiet = 1'b0;

    seed_chain_coherence_filter_unit uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void open_chain();
        chk_first_seed  = 1'b1;
        chk_bad         = 1'b0;
        chk_seed_cnt    = '0;
        chk_next_read   = '0;
        chk_next_genome = '0;
    endfunction

    function automatic bit chain_verdict(input t_seed_word w, output t_result r);
        logic [32:0] gap_limit;
        logic [32:0] gs_wide;
        bit          coh;
        bit          keep;
        r = '0;
        if (w.first_of_list) chk_kept_cnt = '0;
        if (w.empty_location) begin
            open_chain();
            return 1'b1;
        end
        if ((!chk_first_seed && chk_next_read > {1'b0, w.rd_lo}) ||
            w.rd_lo >= w.rd_hi) chk_bad = 1'b1;
        if (!chk_first_seed) begin
            gap_limit = {16'b0, cfg_read_len, 1'b0};
            gs_wide   = {1'b0, w.gn_lo};
            if (gs_wide < chk_next_genome || (gs_wide - chk_next_genome) > gap_limit)
                chk_bad = 1'b1;
        end
        chk_first_seed  = 1'b0;
        chk_next_read   = {1'b0, w.rd_hi} + 17'd1;
        chk_next_genome = {1'b0, w.gn_hi} + 33'd1;
        if (chk_seed_cnt != 8'hFF) chk_seed_cnt++;
        if (!w.last_in_location) return 1'b0;
        coh  = !chk_bad;
        keep = coh && chk_kept_cnt < cfg_max_kept && 32'(chk_kept_cnt) < LIST_CAPACITY;
        r.keep          = keep;
        r.coherent      = coh;
        r.seed_count    = chk_seed_cnt;
        r.kept_position = keep ? chk_kept_cnt : 8'd0;
        if (keep) chk_kept_cnt++;
        open_chain();
        return 1'b1;
    endfunction

    function automatic t_seed_word mk_word(input logic [15:0] rs, input logic [15:0] re,
                                           input logic [31:0] gs, input logic [31:0] ge,
                                           input int last, input int empty,
                                           input int first);
        return '{rs, re, gs, ge, last != 0, empty != 0, first != 0};
    endfunction

    function automatic t_result mk_res(input int keep, input int coh,
                                       input logic [7:0] cnt, input logic [7:0] pos);
        return '{keep != 0, coh != 0, cnt, pos};
    endfunction

    function automatic t_seed_word noise_word(input bit force_empty);
        t_seed_word w;
        w.rd_lo            = 16'($urandom);
        w.rd_hi            = 16'($urandom);
        w.gn_lo            = $urandom;
        w.gn_hi            = $urandom;
        w.last_in_location = 1'($urandom_range(0, 1));
        w.empty_location   = force_empty || ($urandom_range(0, 7) == 0);
        w.first_of_list    = ($urandom_range(0, 7) == 0);
        return w;
    endfunction

    task automatic note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task automatic send_word(input t_seed_word w, input logic typed, input t_result typed_res);
        t_result r;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_rd_lo            <= w.rd_lo;
        i_rd_hi            <= w.rd_hi;
        i_gn_lo            <= w.gn_lo;
        i_gn_hi            <= w.gn_hi;
        i_last_in_location <= w.last_in_location;
        i_empty_location   <= w.empty_location;
        i_first_of_list    <= w.first_of_list;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
        if (chain_verdict(w, r)) expected_results.push_back(typed ? typed_res : r);
    endtask

    task automatic wait_for_quiet();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] rl, input logic [7:0] mk);
        wait_for_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_RD_LEN;
        i_cfg_data  <= rl;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_read_len = rl;
        i_cfg_index <= CFG_MAX_KEPT;
        i_cfg_data  <= {8'($urandom), mk};
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_max_kept = mk;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_location(input int n_seeds, input bit new_list, input bit allow_bad);
        t_seed_word  w;
        logic [16:0] rs_w, re_w, next_r;
        logic [32:0] gs_w, ge_w, next_g, gap_max, gap;
        int          bad_at;
        int          bad_kind;
        gap_max  = {16'b0, cfg_read_len, 1'b0};
        next_r   = 17'($urandom_range(0, 40000));
        next_g   = 33'($urandom_range(1000, 32'hF000_0000));
        bad_at   = (allow_bad && $urandom_range(0, 4) == 0) ? $urandom_range(0, n_seeds - 1) : -1;
        bad_kind = (bad_at == 0) ? 1 : $urandom_range(0, 3);
        for (int i = 0; i < n_seeds; i++) begin
            case ($urandom_range(0, 7))
                0:       gap = '0;
                1:       gap = gap_max;
                default: gap = 33'($urandom_range(0, gap_max[31:0]));
            endcase
            rs_w = (i == 0) ? next_r : next_r + 17'($urandom_range(0, 3));
            gs_w = (i == 0) ? next_g : next_g + gap;
            if (i == bad_at) begin
                case (bad_kind)
                    0:       rs_w = next_r - 17'd1;
                    2:       gs_w = next_g - 33'd1 - 33'($urandom_range(0, 50));
                    3:       gs_w = next_g + gap_max + 33'd1;
                    default: ;
                endcase
            end
            re_w = rs_w + 17'($urandom_range(1, n_seeds > 20 ? 40 : 2000));
            if (i == bad_at && bad_kind == 1) re_w = rs_w;
            ge_w = gs_w + 33'($urandom_range(0, 5000));
            w.rd_lo            = rs_w[15:0];
            w.rd_hi            = re_w[15:0];
            w.gn_lo            = gs_w[31:0];
            w.gn_hi            = ge_w[31:0];
            w.last_in_location = (i == n_seeds - 1);
            w.empty_location   = 1'b0;
            w.first_of_list    = (i == 0) ? new_list : ($urandom_range(0, 40) == 0);
            send_word(w, 1'b0, '0);
            next_r = re_w + 17'd1;
            next_g = ge_w + 33'd1;
        end
    endtask

    task automatic run_random(input int budget);
        int stop_at;
        int pick;
        stop_at = words_sent + budget;
        while (words_sent < stop_at) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
                src_idle_on  = ($urandom_range(0, 2) != 0);
                sink_idle_on = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
                send_location($urandom_range(1, 6), $urandom_range(0, 4) == 0, 1'b1);
            else if (pick < 88)
                send_word(noise_word(1'b0), 1'b0, '0);
            else
                send_word(noise_word(1'b1), 1'b0, '0);
        end
    endtask

    // result side: random stalls, in-order compare
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                note_error($sformatf("word with nothing expected: keep %0d coh %0d cnt %0d pos %0d",
                                     o_keep, o_coherent, o_seed_count, o_kept_position));
            end else begin
                e = expected_results.pop_front();
                if (e.keep !== o_keep)
                    note_error($sformatf("keep expected %0d got %0d", e.keep, o_keep));
                if (e.coherent !== o_coherent)
                    note_error($sformatf("coherent expected %0d got %0d", e.coherent, o_coherent));
                if (e.seed_count !== o_seed_count)
                    note_error($sformatf("seed_count expected %0d got %0d",
                                         e.seed_count, o_seed_count));
                if (e.kept_position !== o_kept_position)
                    note_error($sformatf("kept_position expected %0d got %0d",
                                         e.kept_position, o_kept_position));
            end
        end
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_ready    <= 1'b0;
        end else if (sink_idle_on && !quiet && $urandom_range(0, 5) == 0) begin
            ready_hold <= $urandom_range(0, 6);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        cfg_read_len = 16'd100;
        cfg_max_kept = 8'd100;
        chk_kept_cnt = '0;
        open_chain();

        // typed rows assume the reset values of both registers
        stim_table.push_back('{mk_word(16'd0, 16'd1, 32'd0, 32'd0, 1, 0, 1), 1'b1,
                               mk_res(1, 1, 8'd1, 8'd0)});
        stim_table.push_back('{mk_word(16'd0, 16'd0, 32'd0, 32'd0, 0, 1, 0), 1'b1,
                               mk_res(0, 0, 8'd0, 8'd0)});
        stim_table.push_back('{mk_word(16'hFFFE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0),
                               1'b1, mk_res(1, 1, 8'd1, 8'd1)});
        stim_table.push_back('{mk_word(16'd1234, 16'd1234, 32'd5, 32'd9, 1, 0, 0), 1'b1,
                               mk_res(0, 0, 8'd1, 8'd0)});
        stim_table.push_back('{mk_word(16'hFFFF, 16'd0, 32'd5, 32'd9, 1, 0, 0), 1'b1,
                               mk_res(0, 0, 8'd1, 8'd0)});
        stim_table.push_back('{mk_word(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1),
                               1'b1, mk_res(0, 0, 8'd0, 8'd0)});
        // clean chain, genome gap exactly at the limit
        stim_table.push_back('{mk_word(16'd10, 16'd20, 32'd1000, 32'd1050, 0, 0, 0), 1'b0, '0});
        stim_table.push_back('{mk_word(16'd21, 16'd30, 32'd1051, 32'd1100, 0, 0, 0), 1'b0, '0});
        stim_table.push_back('{mk_word(16'd31, 16'd40, 32'd1301, 32'd1350, 1, 0, 0), 1'b0, '0});
        // gap one past the limit
        stim_table.push_back('{mk_word(16'd100, 16'd200, 32'd5000, 32'd5100, 0, 0, 0), 1'b0, '0});
        stim_table.push_back('{mk_word(16'd201, 16'd300, 32'd5302, 32'd5400, 1, 0, 0), 1'b0, '0});
        // read overlap
        stim_table.push_back('{mk_word(16'd100, 16'd200, 32'd7000, 32'd7100, 0, 0, 0), 1'b0, '0});
        stim_table.push_back('{mk_word(16'd200, 16'd300, 32'd7101, 32'd7200, 1, 0, 0), 1'b0, '0});
        // genome runs backwards
        stim_table.push_back('{mk_word(16'd100, 16'd200, 32'd9000, 32'd9100, 0, 0, 0), 1'b0, '0});
        stim_table.push_back('{mk_word(16'd201, 16'd300, 32'd9100, 32'd9200, 1, 0, 0), 1'b0, '0});
        // empty word drops an open location
        stim_table.push_back('{mk_word(16'd10, 16'd20, 32'd100, 32'd200, 0, 0, 0), 1'b0, '0});
        stim_table.push_back('{mk_word(16'd0, 16'd0, 32'd0, 32'd0, 0, 1, 0), 1'b0, '0});
        // list mark in the middle of a location
        stim_table.push_back('{mk_word(16'd50, 16'd60, 32'd300, 32'd400, 0, 0, 0), 1'b0, '0});
        stim_table.push_back('{mk_word(16'd61, 16'd70, 32'd401, 32'd500, 1, 0, 1), 1'b0, '0});
        // genome end at top, next start wraps to zero
        stim_table.push_back('{mk_word(16'd500, 16'd600, 32'hFFFF_FF00, 32'hFFFF_FFFF, 0, 0, 0),
                               1'b0, '0});
        stim_table.push_back('{mk_word(16'd601, 16'd700, 32'd0, 32'd10, 1, 0, 0), 1'b0, '0});
        // read end at top, next start low
        stim_table.push_back('{mk_word(16'hFFF0, 16'hFFFF, 32'd100, 32'd200, 0, 0, 0), 1'b0, '0});
        stim_table.push_back('{mk_word(16'd0, 16'd5, 32'd201, 32'd300, 1, 0, 0), 1'b0, '0});
        stim_table.push_back('{mk_word(16'h5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1, 0, 0),
                               1'b0, '0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[k])
            send_word(stim_table[k].word, stim_table[k].typed, stim_table[k].res);

        // zero read length: each genome start must follow the previous end
        configure(16'd0, 8'd3);
        run_random(60);
        configure(16'hFFFF, 8'd255);
        send_location(258, 1'b1, 1'b0);
        run_random(60);
        configure(16'($urandom), 8'd0);
        run_random(60);
        configure(16'd17, 8'd1);
        run_random(60);
        quiet        = 1'b1;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        configure(16'($urandom), 8'($urandom));
        run_random(60);

        wait_for_quiet();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/sccf_pkg.sv
design/sccf_front.sv
design/sccf_queue.sv
design/sccf_back.sv
design/seed_chain_coherence_filter_unit.sv
bench/seed_chain_coherence_filter_unit_tb.sv
